// File: rtl/sha1_hash_stream_core_defines.svh
// Assertion macros for the checker file of the SHA-1 stream core.
`ifndef SHA1_HASH_STREAM_CORE_DEFINES_SVH
`define SHA1_HASH_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SHA1HS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SHA1HS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sha1hs_pkg.sv
// Shared types, constants and control structures of the SHA-1 stream core.
package sha1hs_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_WORDS = 5;
    localparam int ROUNDS    = 80;
    localparam int RND_W     = 7;

    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hEFCDAB89;
    localparam word_t IV2 = 32'h98BADCFE;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_in;
        logic       step;
        logic       expand;
    } buf_ctl_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [RND_W-1:0] rnd;
        logic             fold;
        logic             reinit;
    } rnd_ctl_t;

endpackage

// File: rtl/sha1hs_msg_buf.sv
// Block buffer and message schedule: a 512-bit line fed by bytes, stepped by words.
module sha1hs_msg_buf
    import sha1hs_pkg::*;
(
    input  logic     clk,
    input  buf_ctl_t ctl,
    output word_t    w_t
);

    logic [511:0] line_reg;
    logic [511:0] line_next;
    word_t        mix;

    assign mix = line_reg[2*32 +: 32] ^ line_reg[7*32 +: 32]
               ^ line_reg[13*32 +: 32] ^ line_reg[15*32 +: 32];

    assign w_t = ctl.expand ? {mix[30:0], mix[31]} : line_reg[15*32 +: 32];

    always_comb
    begin
        if (ctl.shift_byte)
        begin
            line_next = {line_reg[503:0], ctl.byte_in};
        end
        else if (ctl.step)
        begin
            line_next = {line_reg[479:0], w_t};
        end
        else
        begin
            line_next = line_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

endmodule

// File: rtl/sha1hs_round.sv
// Shared SHA-1 round unit with working variables and chaining words.
module sha1hs_round
    import sha1hs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rnd_ctl_t ctl,
    input  word_t    w_t,
    output word_t    chain [NUM_WORDS]
);

    word_t chain_reg [NUM_WORDS];
    word_t a_reg;
    word_t b_reg;
    word_t c_reg;
    word_t d_reg;
    word_t e_reg;
    word_t f_val;
    word_t k_val;
    word_t t_val;

    always_comb
    begin
        if (ctl.rnd inside {[7'd0:7'd19]})
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (ctl.rnd inside {[7'd20:7'd39]})
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (ctl.rnd inside {[7'd40:7'd59]})
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_t;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctl.step)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
        end
        else if (ctl.reinit)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
        end
        else if (ctl.fold)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    assign chain = chain_reg;

endmodule

// File: rtl/sha1_hash_stream_core.sv
// Top level of the SHA-1 byte stream hashing core with its sequencer.
//
// The slave channel takes one beat per message byte: tuser holds the command
// (absorb, absorb then finish, or finish alone) and tdata the byte. The master
// channel returns the digest as five beats of 32 bits, word 0 first, with the
// word index on tuser and tlast on the fifth beat.
// An absorbed byte is shifted into the block buffer. The byte that fills a 64-byte
// block starts the single round unit, which runs the 80 rounds and then folds
// the result into the chaining words while no byte is taken. A finish writes
// the padding and length byte by byte up to the end of the block and
// compresses it, and a second block when the length spills into one. After
// the last fold the emit state loads the first digest beat into the output
// register.
// tready is high only while the core waits for a byte. A stalled receiver
// holds the digest beat in its output register and the core simply waits.
// After the fifth beat the chaining words return to their initial values.
// Reset clears the byte count and bit length and loads the initial chaining
// words; the block buffer holds no defined value until it is written.
module sha1_hash_stream_core
    import sha1hs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD0,
        ST_PADZ,
        ST_LEN,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    state_t           ret_reg;
    state_t           ret_next;
    logic [5:0]       fill_reg;
    logic [5:0]       fill_next;
    logic [63:0]      bitlen_reg;
    logic [63:0]      bitlen_next;
    logic [RND_W-1:0] rnd_reg;
    logic [RND_W-1:0] rnd_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic [2:0]       idx_inc;
    logic             out_valid_reg;
    logic             out_valid_next;
    word_t            out_data_reg;
    word_t            out_data_next;
    logic             out_last_reg;
    logic             out_last_next;
    buf_ctl_t         bctl;
    rnd_ctl_t         rctl;
    word_t            w_t;
    word_t            chain [NUM_WORDS];

    sha1hs_msg_buf u_buf
    (
        .clk (clk),
        .ctl (bctl),
        .w_t (w_t)
    );

    sha1hs_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rctl),
        .w_t   (w_t),
        .chain (chain)
    );

    assign idx_inc = idx_reg + 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        bctl           = '0;
        bctl.expand    = (rnd_reg >= RND_W'(16));
        rctl           = '0;
        rctl.rnd       = rnd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        CMD_ABSORB, CMD_ABSORB_FINISH:
                        begin
                            bctl.shift_byte = 1'b1;
                            bctl.byte_in    = s_axis_tdata;
                            fill_next       = fill_reg + 6'd1;
                            bitlen_next     = bitlen_reg + 64'd8;
                            if (fill_reg == 6'd63)
                            begin
                                rctl.load  = 1'b1;
                                rnd_next   = '0;
                                state_next = ST_ROUND;
                                ret_next   = (s_axis_tuser == CMD_ABSORB_FINISH) ?
                                             ST_PAD0 : ST_IDLE;
                            end
                            else if (s_axis_tuser == CMD_ABSORB_FINISH)
                            begin
                                state_next = ST_PAD0;
                            end
                        end
                        CMD_FINISH:
                        begin
                            state_next = ST_PAD0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROUND:
            begin
                bctl.step = 1'b1;
                rctl.step = 1'b1;
                rnd_next  = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                rctl.fold  = 1'b1;
                state_next = ret_reg;
            end
            ST_PAD0:
            begin
                bctl.shift_byte = 1'b1;
                bctl.byte_in    = PAD_BYTE;
                fill_next       = fill_reg + 6'd1;
                state_next      = ST_PADZ;
                if (fill_reg == 6'd63)
                begin
                    rctl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                    ret_next   = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (fill_reg == 6'd56)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    bctl.shift_byte = 1'b1;
                    bctl.byte_in    = 8'h00;
                    fill_next       = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        rctl.load  = 1'b1;
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                        ret_next   = ST_PADZ;
                    end
                end
            end
            ST_LEN:
            begin
                bctl.shift_byte = 1'b1;
                bctl.byte_in    = bitlen_reg[63:56];
                bitlen_next     = {bitlen_reg[55:0], bitlen_reg[63:56]};
                fill_next       = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    rctl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = chain[0];
                    out_last_next  = 1'b0;
                    idx_next       = '0;
                end
                else if (m_axis_tready)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        out_last_next  = 1'b0;
                        rctl.reinit    = 1'b1;
                        bitlen_next    = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_data_next = chain[idx_inc];
                        out_last_next = (idx_inc == 3'(NUM_WORDS - 1));
                        idx_next      = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            bitlen_reg    <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bitlen_reg    <= bitlen_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/sha1hs_checker.sv
// Port-level checker for the SHA-1 stream core and its bind statement.
`include "sha1_hash_stream_core_defines.svh"

module sha1hs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic [35:0] beat;
    logic        out_stall;
    logic        out_step;
    logic        idx_last;
    logic [2:0]  idx_exp_reg;
    logic [2:0]  idx_exp_next;
    logic        seq_ok;

    assign beat         = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_step     = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign idx_last     = (m_axis_tuser == 3'd4);
    assign idx_exp_next = m_axis_tuser + 3'd1;
    assign seq_ok       = m_axis_tvalid && (m_axis_tuser == idx_exp_reg);

    always_ff @(posedge clk)
    begin
        idx_exp_reg <= idx_exp_next;
    end

    // A stalled digest beat keeps its contents.
    `SHA1HS_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(beat), "held beat changed")

    // The fifth word alone carries tlast.
    `SHA1HS_ASSERT_IMP(a_last_idx, m_axis_tvalid, m_axis_tlast == idx_last, "tlast off word four")

    // No byte is taken while a digest is being delivered.
    `SHA1HS_ASSERT_IMP(a_no_input_emit, m_axis_tvalid, !s_axis_tready, "input ready in digest")

    // Digest words follow one another without a gap.
    `SHA1HS_ASSERT_NXT(a_word_seq, out_step, seq_ok, "digest words out of sequence")

endmodule

bind sha1_hash_stream_core sha1hs_checker u_sha1hs_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the SHA-1 byte stream core, with its own digest predictor.
module tb;
    import sha1hs_pkg::*;

    localparam logic [1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [159:0] SHA1_IV      = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [159:0] EMPTY_DIGEST = 160'hDA39A3EE_5E6B4B0D_3255BFEF_95601890_AFD80709;
    localparam logic [31:0]  K_R0         = 32'h5A827999;
    localparam logic [31:0]  K_R1         = 32'h6ED9EBA1;
    localparam logic [31:0]  K_R2         = 32'h8F1BBCDC;
    localparam logic [31:0]  K_R3         = 32'hCA62C1D6;
    localparam logic [7:0]   MARKER_BYTE  = 8'h80;
    localparam int DIR_N        = 14;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int RAND_BUDGET  = 70;
    localparam int PHASE_SWAP   = 24;
    localparam int PHASE_FREE   = 48;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [7:0] reps;
        logic       empty_known;
    } stim_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [1:0]  s_axis_tuser  = CMD_ABSORB;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0]  hash_state [0:4];
    logic [7:0]   msg_block [0:63];
    int           fill_cnt;
    logic [63:0]  msg_bits;
    digest_beat_t digest_q [$];
    stim_row_t    dir_rows [0:DIR_N-1];

    int errors;
    int beats_sent;
    int msgs_done;
    int words_expected;
    int words_checked;
    int src_idle_pct;
    int sink_stall_pct;
    bit hold_req;
    bit hold_done;

    sha1_hash_stream_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void load_iv();
        int i;
        for (i = 0; i < 5; i++)
        begin
            hash_state[i] = SHA1_IV[159 - 32 * i -: 32];
        end
        fill_cnt = 0;
        msg_bits = 64'd0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        int          i;
        for (i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4 * i], msg_block[4 * i + 1], msg_block[4 * i + 2],
                    msg_block[4 * i + 3]};
        end
        for (i = 16; i < 80; i++)
        begin
            w[i] = rol32(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K_R1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    // Advances the hash state by one accepted beat, skipping unused commands, and queues the digest on a finish.
    function automatic void predict_digest(input logic [1:0] cmd, input logic [7:0] data,
                                           input bit empty_known);
        digest_beat_t b;
        int           i;
        if (cmd == CMD_UNUSED)
            return;
        if (cmd != CMD_FINISH)
        begin
            msg_block[fill_cnt] = data;
            fill_cnt++;
            msg_bits = msg_bits + 64'd8;
            if (fill_cnt == 64)
            begin
                sha_compress();
                fill_cnt = 0;
            end
        end
        if (cmd == CMD_ABSORB)
            return;
        msg_block[fill_cnt] = MARKER_BYTE;
        fill_cnt++;
        if (fill_cnt > 56)
        begin
            while (fill_cnt < 64)
            begin
                msg_block[fill_cnt] = 8'h00;
                fill_cnt++;
            end
            sha_compress();
            fill_cnt = 0;
        end
        while (fill_cnt < 56)
        begin
            msg_block[fill_cnt] = 8'h00;
            fill_cnt++;
        end
        for (i = 0; i < 8; i++)
        begin
            msg_block[56 + i] = msg_bits[63 - 8 * i -: 8];
        end
        sha_compress();
        for (i = 0; i < NUM_WORDS; i++)
        begin
            b.word = empty_known ? EMPTY_DIGEST[159 - 32 * i -: 32] : hash_state[i];
            b.idx  = i[2:0];
            b.last = (i == NUM_WORDS - 1);
            digest_q.insert(digest_q.size(), b);
            words_expected++;
        end
        msgs_done++;
        load_iv();
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data,
                             input bit empty_known);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_digest(cmd, data, empty_known);
        beats_sent++;
    endtask

    initial
    begin : main
        int rand_beats;
        int msg_len;
        int body_len;
        int r;
        int j;
        bit with_byte;
        errors         = 0;
        beats_sent     = 0;
        msgs_done      = 0;
        words_expected = 0;
        words_checked  = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        src_idle_pct   = 8;
        sink_stall_pct = 47;
        rand_beats     = 0;
        load_iv();
        dir_rows = '{
            '{CMD_FINISH,        8'h00, 8'd1,  1'b1},
            '{CMD_UNUSED,        8'hFF, 8'd1,  1'b0},
            '{CMD_FINISH,        8'hFF, 8'd1,  1'b1},
            '{CMD_ABSORB_FINISH, 8'h00, 8'd1,  1'b0},
            '{CMD_ABSORB_FINISH, 8'hFF, 8'd1,  1'b0},
            '{CMD_ABSORB,        8'h61, 8'd1,  1'b0},
            '{CMD_ABSORB,        8'h62, 8'd1,  1'b0},
            '{CMD_UNUSED,        8'h00, 8'd1,  1'b0},
            '{CMD_ABSORB_FINISH, 8'h63, 8'd1,  1'b0},
            '{CMD_ABSORB,        8'hA5, 8'd55, 1'b0},
            '{CMD_ABSORB_FINISH, 8'h5A, 8'd1,  1'b0},
            '{CMD_ABSORB,        8'hFF, 8'd63, 1'b0},
            '{CMD_ABSORB_FINISH, 8'h00, 8'd1,  1'b0},
            '{CMD_FINISH,        8'h55, 8'd1,  1'b1}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_N; r++)
        begin
            for (j = 0; j < dir_rows[r].reps; j++)
            begin
                send_beat(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].empty_known);
            end
        end

        while (rand_beats < RAND_BUDGET || !hold_req)
        begin
            if (rand_beats >= PHASE_FREE)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            else if (rand_beats >= PHASE_SWAP)
            begin
                src_idle_pct   = 47;
                sink_stall_pct = 8;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                msg_len = $urandom_range(0, 12);
            else if (r < 80)
                msg_len = $urandom_range(52, 66);
            else if (r < 92)
                msg_len = $urandom_range(13, 51);
            else
                msg_len = $urandom_range(100, 140);
            // A short message while the receiver holds off, so the digest backs up.
            if (rand_beats >= PHASE_FREE && !hold_req)
            begin
                hold_req = 1'b1;
                msg_len  = $urandom_range(0, 4);
            end
            with_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            body_len  = with_byte ? msg_len - 1 : msg_len;
            for (j = 0; j < body_len; j++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
                send_beat(CMD_ABSORB, 8'($urandom_range(0, 255)), 1'b0);
                rand_beats++;
            end
            if (with_byte)
                send_beat(CMD_ABSORB_FINISH, 8'($urandom_range(0, 255)), 1'b0);
            else
                send_beat(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0);
            rand_beats++;
        end
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d input beats forming %0d messages; %0d of %0d digest words checked.",
                 beats_sent, msgs_done, words_checked, words_expected);
        $display("Included padding spill, exact block fill, ignored commands and a long hold-off.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : sink
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : digest_check
        digest_beat_t exp_b;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest beat: expected none, actual %h idx %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                exp_b = digest_q.pop_front();
                words_checked++;
                if (m_axis_tdata !== exp_b.word)
                begin
                    errors++;
                    $display("%0t: digest word mismatch: expected %h, actual %h",
                             $time, exp_b.word, m_axis_tdata);
                end
                if (m_axis_tuser !== exp_b.idx)
                begin
                    errors++;
                    $display("%0t: word index mismatch: expected %0d, actual %0d",
                             $time, exp_b.idx, m_axis_tuser);
                end
                if (m_axis_tlast !== exp_b.last)
                begin
                    errors++;
                    $display("%0t: tlast mismatch: expected %b, actual %b",
                             $time, exp_b.last, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stale = 0;
            else
                stale++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sha1_hash_stream_core.f
+incdir+rtl
rtl/sha1hs_pkg.sv
rtl/sha1hs_msg_buf.sv
rtl/sha1hs_round.sv
rtl/sha1_hash_stream_core.sv
rtl/sha1hs_checker.sv
tb/sv/tb.sv
